// File: sv/lkfr_pkg.sv
// Shared types and constants for the LRU-K frame replacer.
// Used by lkfr_victim_sel and lru_k_frame_replacer; depends on nothing.
package lkfr_pkg;

    // Field widths fixed by the request and result formats
    localparam int FRAME_W   = 6;
    localparam int FRAME_SPACE = 64;
    localparam int VISIT_W   = 4;
    localparam int COUNT_W   = 7;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;
    localparam int K_W       = 4;

    localparam logic [VISIT_W-1:0] VISIT_MAX = 4'd15;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ACCESS   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET_EVICT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EVICT    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_K_VALUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;

    // Control for one candidate presented to the victim selector
    typedef struct packed {
        logic               clear;
        logic               live;
        logic               tracked;
        logic               may_evict;
        logic               in_lru;
        logic [VISIT_W-1:0] visits;
    } lkfr_cand_t;

endpackage

// File: sv/lkfr_slot_ram.sv
// Per-slot state memory: one write port, one read port, registered read.
// Generic; depends on nothing.
module lkfr_slot_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 38
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/lkfr_victim_sel.sv
// Running best-candidate tracker for the eviction scan.
// Depends on lkfr_pkg for the candidate control struct.
module lkfr_victim_sel #(
    parameter int IDX_W      = 6,
    parameter int STAMP_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lkfr_pkg::lkfr_cand_t  cand,
    input  logic [IDX_W-1:0]      cand_idx,
    input  logic [STAMP_BITS-1:0] cand_stamp,
    input  logic [STAMP_BITS-1:0] access_clock,
    output logic                  best_found,
    output logic [IDX_W-1:0]      best_idx
);

    logic                         found_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic                         lru_reg;
    logic [lkfr_pkg::VISIT_W-1:0] visits_reg;
    logic [STAMP_BITS-1:0]        age_reg;

    logic [STAMP_BITS-1:0] cand_age;
    logic                  eligible;
    logic                  older;
    logic                  better;

    // Rank the candidate: history tier first, then fewer visits (history tier only), then older
    always_comb
    begin
        cand_age = access_clock - cand_stamp;
        eligible = cand.live && cand.tracked && cand.may_evict;
        older    = cand_age > age_reg;
        better   = 1'b0;
        if (!found_reg)
        begin
            better = 1'b1;
        end
        else if (!cand.in_lru && lru_reg)
        begin
            better = 1'b1;
        end
        else if (cand.in_lru == lru_reg)
        begin
            if (cand.in_lru)
            begin
                better = older;
            end
            else
            begin
                better = (cand.visits < visits_reg) || ((cand.visits == visits_reg) && older);
            end
        end
    end

    // Hold the best so far; clear at the start of each scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cand.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (eligible && better)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cand.clear && eligible && better)
        begin
            idx_reg    <= cand_idx;
            lru_reg    <= cand.in_lru;
            visits_reg <= cand.visits;
            age_reg    <= cand_age;
        end
    end

    assign best_found = found_reg;
    assign best_idx   = idx_reg;

endmodule

// File: sv/lru_k_frame_replacer.sv
// LRU-K frame replacer top level; depends on lkfr_pkg, lkfr_slot_ram and lkfr_victim_sel.
// Access, set evictable and remove hold busy through a slot read, then an update;
// evict holds busy to scan min(FRAME_SLOTS,64) slots, one read per cycle, then drain and finish.
// The result strobe is high for one cycle, the first with busy low, and cannot be stalled; a new
// start is taken in that cycle; no new request is taken while one is in progress.
// Reset clears the tracked bits, counters and clock at once; slot memory contents need no clear.
module lru_k_frame_replacer #(
    parameter int FRAME_SLOTS = 64,
    parameter int STAMP_BITS  = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [lkfr_pkg::REQ_W-1:0]         req_type,
    input  logic [lkfr_pkg::FRAME_W-1:0]       req_frame,
    input  logic                               evictable_flag,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lkfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lkfr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               result_valid,
    output logic                               victim_valid,
    output logic [lkfr_pkg::FRAME_W-1:0]       victim_frame,
    output logic [lkfr_pkg::COUNT_W-1:0]       evictable_count,
    output logic                               access_dropped
);

    // Only frames the request field can name are ever tracked
    localparam int TRACK_N = (FRAME_SLOTS < lkfr_pkg::FRAME_SPACE) ?
                             FRAME_SLOTS : lkfr_pkg::FRAME_SPACE;
    localparam int IDX_W   = $clog2(TRACK_N);
    localparam int VW      = lkfr_pkg::VISIT_W;
    localparam int CW      = lkfr_pkg::COUNT_W;
    localparam int ENT_W   = STAMP_BITS + VW + 2;
    localparam logic [lkfr_pkg::FRAME_W:0] TRACK_LIM = (lkfr_pkg::FRAME_W + 1)'(TRACK_N);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACK_N - 1);

    // Controller states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [lkfr_pkg::REQ_W-1:0]   req_reg;
    logic [lkfr_pkg::FRAME_W-1:0] frame_reg;
    logic                         flag_reg;

    logic [lkfr_pkg::K_W-1:0] k_reg;
    logic [CW-1:0]            cap_reg;

    logic [TRACK_N-1:0]    tracked_reg, tracked_next;
    logic [STAMP_BITS-1:0] clock_reg, clock_next;
    logic [CW-1:0]         tt_reg, tt_next;
    logic [CW-1:0]         ev_reg, ev_next;

    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             rd_live_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    logic                         res_valid_reg, res_valid_next;
    logic                         vic_valid_reg, vic_valid_next;
    logic [lkfr_pkg::FRAME_W-1:0] vic_frame_reg, vic_frame_next;
    logic                         dropped_reg, dropped_next;

    logic             accept;
    logic             in_range;
    logic [IDX_W-1:0] slot;
    logic             trk;

    logic             wr_en;
    logic [ENT_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;

    logic                  q_lru;
    logic [VW-1:0]         q_visits;
    logic                  q_may;
    logic [STAMP_BITS-1:0] q_stamp;
    logic [VW-1:0]         new_visits;
    logic                  new_lru;

    lkfr_pkg::lkfr_cand_t cand;
    logic                 best_found;
    logic [IDX_W-1:0]     best_idx;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign in_range = {1'b0, frame_reg} < TRACK_LIM;
    assign slot     = frame_reg[IDX_W-1:0];
    assign trk      = in_range && tracked_reg[slot];

    // Unpack the slot entry
    assign q_lru    = rd_data[STAMP_BITS+VW+1];
    assign q_visits = rd_data[STAMP_BITS+VW:STAMP_BITS+1];
    assign q_may    = rd_data[STAMP_BITS];
    assign q_stamp  = rd_data[STAMP_BITS-1:0];

    assign rd_addr = (state_reg == ST_SCAN) ? scan_idx_reg : slot;

    lkfr_slot_ram #(
        .DEPTH (TRACK_N),
        .WIDTH (ENT_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Present scan data to the selector
    always_comb
    begin
        cand.clear     = accept && (req_type == lkfr_pkg::REQ_EVICT);
        cand.live      = rd_live_reg;
        cand.tracked   = tracked_reg[rd_idx_reg];
        cand.may_evict = q_may;
        cand.in_lru    = q_lru;
        cand.visits    = q_visits;
    end

    lkfr_victim_sel #(
        .IDX_W      (IDX_W),
        .STAMP_BITS (STAMP_BITS)
    ) u_sel (
        .clk          (clk),
        .rst_n        (rst_n),
        .cand         (cand),
        .cand_idx     (rd_idx_reg),
        .cand_stamp   (q_stamp),
        .access_clock (clock_reg),
        .best_found   (best_found),
        .best_idx     (best_idx)
    );

    // Visit count update for a repeat access
    always_comb
    begin
        if (q_lru)
        begin
            new_visits = q_visits;
            new_lru    = 1'b1;
        end
        else
        begin
            new_visits = (q_visits < lkfr_pkg::VISIT_MAX) ? (q_visits + 1'b1) : q_visits;
            new_lru    = new_visits >= k_reg;
        end
    end

    // Sequencer and read-modify-write
    always_comb
    begin
        state_next     = state_reg;
        tracked_next   = tracked_reg;
        clock_next     = clock_reg;
        tt_next        = tt_reg;
        ev_next        = ev_reg;
        scan_idx_next  = scan_idx_reg;
        res_valid_next = 1'b0;
        vic_valid_next = 1'b0;
        vic_frame_next = '0;
        dropped_next   = 1'b0;
        wr_en          = 1'b0;
        wr_data        = rd_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == lkfr_pkg::REQ_EVICT)
                    begin
                        state_next    = ST_SCAN;
                        scan_idx_next = '0;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next     = ST_IDLE;
                res_valid_next = 1'b1;
                case (req_reg)
                    lkfr_pkg::REQ_ACCESS:
                    begin
                        if (trk)
                        begin
                            clock_next = clock_reg + 1'b1;
                            wr_en      = 1'b1;
                            wr_data    = {new_lru, new_visits, q_may, clock_next};
                        end
                        else if (in_range && (tt_reg >= cap_reg))
                        begin
                            dropped_next = 1'b1;
                        end
                        else if (in_range)
                        begin
                            clock_next          = clock_reg + 1'b1;
                            wr_en               = 1'b1;
                            wr_data             = {1'b0, VW'(1), 1'b1, clock_next};
                            tracked_next[slot]  = 1'b1;
                            tt_next             = tt_reg + 1'b1;
                            ev_next             = ev_reg + 1'b1;
                        end
                    end
                    lkfr_pkg::REQ_SET_EVICT:
                    begin
                        if (trk && (q_may != flag_reg))
                        begin
                            wr_en   = 1'b1;
                            wr_data = {q_lru, q_visits, flag_reg, q_stamp};
                            if (flag_reg)
                            begin
                                ev_next = ev_reg + 1'b1;
                            end
                            else if (ev_reg != '0)
                            begin
                                ev_next = ev_reg - 1'b1;
                            end
                        end
                    end
                    lkfr_pkg::REQ_REMOVE:
                    begin
                        if (trk)
                        begin
                            tracked_next[slot] = 1'b0;
                            if (q_may && (ev_reg != '0))
                            begin
                                ev_next = ev_reg - 1'b1;
                            end
                            if (tt_reg != '0)
                            begin
                                tt_next = tt_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next     = ST_IDLE;
                res_valid_next = 1'b1;
                if (best_found)
                begin
                    vic_valid_next         = 1'b1;
                    vic_frame_next         = lkfr_pkg::FRAME_W'(best_idx);
                    tracked_next[best_idx] = 1'b0;
                    if (ev_reg != '0)
                    begin
                        ev_next = ev_reg - 1'b1;
                    end
                    if (tt_reg != '0)
                    begin
                        tt_next = tt_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tracked_reg   <= '0;
            clock_reg     <= '0;
            tt_reg        <= '0;
            ev_reg        <= '0;
            scan_idx_reg  <= '0;
            rd_live_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            k_reg         <= 4'd2;
            cap_reg       <= 7'd64;
        end
        else
        begin
            state_reg     <= state_next;
            tracked_reg   <= tracked_next;
            clock_reg     <= clock_next;
            tt_reg        <= tt_next;
            ev_reg        <= ev_next;
            scan_idx_reg  <= scan_idx_next;
            rd_live_reg   <= (state_reg == ST_SCAN);
            res_valid_reg <= res_valid_next;
            // Take a configuration transfer
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lkfr_pkg::CFG_K_VALUE:  k_reg   <= cfg_data[lkfr_pkg::K_W-1:0];
                    lkfr_pkg::CFG_CAPACITY: cap_reg <= cfg_data[CW-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            frame_reg <= req_frame;
            flag_reg  <= evictable_flag;
        end
        rd_idx_reg    <= scan_idx_reg;
        vic_valid_reg <= vic_valid_next;
        vic_frame_reg <= vic_frame_next;
        dropped_reg   <= dropped_next;
    end

    assign result_valid    = res_valid_reg;
    assign victim_valid    = vic_valid_reg && res_valid_reg;
    assign victim_frame    = vic_frame_reg;
    assign evictable_count = ev_reg;
    assign access_dropped  = dropped_reg && res_valid_reg;

    // A result is shown only once the request has finished
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> !busy)
        else $error("result strobe while busy");

    // The evictable count never exceeds the tracked count
    assert property (@(posedge clk) disable iff (!rst_n) ev_reg <= tt_reg)
        else $error("evictable count exceeds tracked count");

    // An accepted request keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> busy)
        else $error("accepted request did not start");

    // A dropped access never reports a victim
    assert property (@(posedge clk) disable iff (!rst_n) access_dropped |-> !victim_valid)
        else $error("dropped access with victim");

    // Tracked count matches the tracked bits
    assert property (@(posedge clk) disable iff (!rst_n)
        CW'($countones(tracked_reg)) == tt_reg)
        else $error("tracked count out of step");

endmodule
